FILE: design/tga_rle_pixel_decoder_defines.svh
// assertion macros shared by the tga rle decoder modules
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TGA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tga_pkg.sv
// shared types and constants of the tga rle pixel decoder
package tga_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned DIM_W       = 16;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned HOLD_W      = 24;
    localparam int unsigned PIX_W       = 32;

    // packet header coding
    localparam logic [BYTE_W-1:0] RUN_FLAG = 8'd128;
    localparam logic [BYTE_W-1:0] RUN_BIAS = 8'd127;
    localparam logic [BYTE_W-1:0] REP_MAX  = 8'd128;

    typedef enum logic [1:0] {
        PH_STOP = 2'd0,
        PH_HEAD = 2'd1,
        PH_PIX  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_ZERO_SIZE = 2'd1,
        ERR_OVERRUN   = 2'd2,
        ERR_TRUNC     = 2'd3
    } t_err;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_ALPHA  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic               has_alpha;
        logic [COUNT_W-1:0] total;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              image_start;
        logic              stream_end;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
        logic [BYTE_W-1:0]  alpha;
        logic [BYTE_W-1:0]  repeat_res;
        logic [COUNT_W-1:0] first_pixel_index;
        logic               image_done;
        t_err               error_code;
    } t_result;

endpackage

FILE: design/tga_rle_pixel_decoder.sv
// top level of the tga run-length pixel decoder
// Decodes the run-length compressed pixel data of a TGA image, one stream byte
// per input beat, and gives one result beat per completed pixel: the colour in
// RGB(A) order, how many pixels it covers (a whole run at once) and the index of
// its first pixel, plus image_done and an error code (zero size, too many pixels,
// truncated stream). Empty results (repeat 0) carry only an error code and a
// pixel index. After the image ends or an error is flagged, bytes are dropped
// until a beat marked with image_start. A new input beat is taken every cycle
// unless stalled; a beat is held in the input register and its result is then
// loaded into the result register. Throughput is one byte per clock, set by the
// combinational decode step between the two registers, and only held back while
// the result register is full and not being taken. The configuration port is
// always ready; write width, height and alpha only while no beat is in flight.
module tga_rle_pixel_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tga_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [tga_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // stream input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tga_pkg::BYTE_W-1:0]          i_stream_byte,
    input  logic                                i_image_start,
    input  logic                                i_stream_end,
    // pixel results
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tga_pkg::BYTE_W-1:0]          o_red,
    output logic [tga_pkg::BYTE_W-1:0]          o_green,
    output logic [tga_pkg::BYTE_W-1:0]          o_blue,
    output logic [tga_pkg::BYTE_W-1:0]          o_alpha,
    output logic [tga_pkg::BYTE_W-1:0]          o_repeat_res,
    output logic [tga_pkg::COUNT_W-1:0]         o_first_pixel_index,
    output logic                                o_image_done,
    output logic [1:0]                          o_error_code
);

    tga_pkg::t_cfg    w_cfg;
    tga_pkg::t_item   w_in_item;
    tga_pkg::t_item   w_item;
    logic             w_item_valid;
    logic             w_advance;
    logic             w_out_free;
    logic             w_emit;
    tga_pkg::t_result w_result;
    tga_pkg::t_result w_out;

    // register writes never stall
    assign o_cfg_ready = 1'b1;

    tga_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_in_item.stream_byte = i_stream_byte;
    assign w_in_item.image_start = i_image_start;
    assign w_in_item.stream_end  = i_stream_end;

    tga_inreg u_inreg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    // a held beat is decoded once the result register can take its result
    assign w_advance = w_item_valid && w_out_free;

    tga_dec u_dec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_item),
        .i_cfg     (w_cfg),
        .o_emit    (w_emit),
        .o_result  (w_result)
    );

    tga_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_emit),
        .i_result (w_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (w_out_free),
        .o_result (w_out)
    );

    // result fields out to their own ports
    assign o_red               = w_out.red;
    assign o_green             = w_out.green;
    assign o_blue              = w_out.blue;
    assign o_alpha             = w_out.alpha;
    assign o_repeat_res        = w_out.repeat_res;
    assign o_first_pixel_index = w_out.first_pixel_index;
    assign o_image_done        = w_out.image_done;
    assign o_error_code        = w_out.error_code;

endmodule

FILE: design/tga_cfg.sv
// configuration registers and the pixel total of the image
module tga_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_valid,
    input  logic [tga_pkg::CFG_INDEX_W-1:0]     i_wr_index,
    input  logic [tga_pkg::CFG_DATA_W-1:0]      i_wr_data,
    output tga_pkg::t_cfg                       o_cfg
);

    logic [tga_pkg::DIM_W-1:0]   r_width, n_width;
    logic [tga_pkg::DIM_W-1:0]   r_height, n_height;
    logic                        r_has_alpha, n_has_alpha;
    logic [tga_pkg::COUNT_W-1:0] r_total;

    always_comb begin
        n_width     = r_width;
        n_height    = r_height;
        n_has_alpha = r_has_alpha;
        if (i_wr_valid) begin
            unique case (tga_pkg::t_cfg_idx'(i_wr_index))
                tga_pkg::CFG_WIDTH:  n_width     = i_wr_data;
                tga_pkg::CFG_HEIGHT: n_height    = i_wr_data;
                tga_pkg::CFG_ALPHA:  n_has_alpha = i_wr_data[0];
                default: ;
            endcase
        end
    end

    // total follows the written values in the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= tga_pkg::DIM_W'(1);
            r_height    <= tga_pkg::DIM_W'(1);
            r_has_alpha <= 1'b0;
            r_total     <= tga_pkg::COUNT_W'(1);
        end else begin
            r_width     <= n_width;
            r_height    <= n_height;
            r_has_alpha <= n_has_alpha;
            r_total     <= tga_pkg::COUNT_W'(n_width) * tga_pkg::COUNT_W'(n_height);
        end
    end

    assign o_cfg.width     = r_width;
    assign o_cfg.height    = r_height;
    assign o_cfg.has_alpha = r_has_alpha;
    assign o_cfg.total     = r_total;

endmodule

FILE: design/tga_inreg.sv
// input register stage for incoming stream beats
module tga_inreg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tga_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output tga_pkg::t_item o_item
);

    logic           r_valid;
    tga_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: design/tga_dec.sv
// packet decode state and the per-byte decode step
`include "tga_rle_pixel_decoder_defines.svh"

module tga_dec (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  tga_pkg::t_item   i_item,
    input  tga_pkg::t_cfg    i_cfg,
    output logic             o_emit,
    output tga_pkg::t_result o_result
);

    tga_pkg::t_phase             r_phase, n_phase;
    logic [tga_pkg::BYTE_W-1:0]  r_left, n_left;
    logic                        r_run, n_run;
    logic [1:0]                  r_slot, n_slot;
    logic [tga_pkg::HOLD_W-1:0]  r_hold, n_hold;
    logic [tga_pkg::COUNT_W-1:0] r_pd, n_pd;

    tga_pkg::t_phase             phase_eff;
    logic [tga_pkg::COUNT_W-1:0] pd_eff;
    logic [tga_pkg::PIX_W-1:0]   pix;
    logic [tga_pkg::COUNT_W-1:0] rem;
    logic [tga_pkg::BYTE_W-1:0]  want;
    logic [tga_pkg::BYTE_W-1:0]  rep;
    logic [tga_pkg::BYTE_W-1:0]  left_after;
    logic [tga_pkg::COUNT_W-1:0] pd_sum;
    logic                        rem_lt_want;
    logic                        done;
    logic                        over;
    logic                        complete;
    logic                        emit_c;
    tga_pkg::t_result            res;

    assign phase_eff = i_item.image_start ? tga_pkg::PH_HEAD : r_phase;
    assign pd_eff    = i_item.image_start ? '0 : r_pd;

    // byte lands in its slot of the pixel word
    assign pix = {8'd0, r_hold}
               | ({24'd0, i_item.stream_byte} << {r_slot, 3'b000});

    assign rem  = (i_cfg.total > pd_eff) ? (i_cfg.total - pd_eff) : '0;
    assign want = r_run ? r_left : 8'd1;
    assign rem_lt_want = rem < {24'd0, want};
    assign done = rem <= {24'd0, want};
    assign rep  = rem_lt_want ? rem[tga_pkg::BYTE_W-1:0] : want;
    assign left_after = r_run ? 8'd0 : (r_left - 8'd1);
    assign over = rem_lt_want || (done && (left_after != 8'd0));
    assign pd_sum = pd_eff + {24'd0, rep};
    assign complete = (r_slot == 2'd3) || ((r_slot == 2'd2) && !i_cfg.has_alpha);

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_run   = r_run;
        n_slot  = r_slot;
        n_hold  = r_hold;
        n_pd    = r_pd;
        emit_c  = 1'b0;
        res     = '0;

        if (i_item.image_start) begin
            n_left = '0;
            n_run  = 1'b0;
            n_slot = '0;
            n_hold = '0;
            n_pd   = '0;
        end

        if (i_item.image_start && (i_cfg.total == '0)) begin
            n_phase        = tga_pkg::PH_STOP;
            emit_c         = 1'b1;
            res.error_code = tga_pkg::ERR_ZERO_SIZE;
        end else begin
            unique case (phase_eff)
                tga_pkg::PH_HEAD: begin
                    if (i_item.stream_byte < tga_pkg::RUN_FLAG) begin
                        n_run  = 1'b0;
                        n_left = i_item.stream_byte + 8'd1;
                    end else begin
                        n_run  = 1'b1;
                        n_left = i_item.stream_byte - tga_pkg::RUN_BIAS;
                    end
                    n_slot  = '0;
                    n_hold  = '0;
                    n_phase = tga_pkg::PH_PIX;
                end
                tga_pkg::PH_PIX: begin
                    if (complete) begin
                        emit_c = 1'b1;
                        if (rep != 8'd0) begin
                            res.red   = pix[23:16];
                            res.green = pix[15:8];
                            res.blue  = pix[7:0];
                            res.alpha = i_cfg.has_alpha ? pix[31:24] : 8'd0;
                        end
                        res.repeat_res        = rep;
                        res.first_pixel_index = pd_eff;
                        n_pd   = pd_sum;
                        n_slot = '0;
                        n_hold = '0;
                        if (done) begin
                            n_phase        = tga_pkg::PH_STOP;
                            res.image_done = 1'b1;
                            res.error_code = over ? tga_pkg::ERR_OVERRUN : tga_pkg::ERR_NONE;
                        end else begin
                            n_left = left_after;
                            if (left_after == 8'd0) begin
                                n_phase = tga_pkg::PH_HEAD;
                            end
                        end
                    end else begin
                        n_slot = r_slot + 2'd1;
                        n_hold = pix[tga_pkg::HOLD_W-1:0];
                    end
                end
                default: begin
                    n_phase = tga_pkg::PH_STOP;
                end
            endcase

            // stream ran out with the image unfinished
            if (i_item.stream_end && (n_phase != tga_pkg::PH_STOP)) begin
                n_phase = tga_pkg::PH_STOP;
                if (emit_c) begin
                    res.error_code = tga_pkg::ERR_TRUNC;
                end else begin
                    emit_c                = 1'b1;
                    res                   = '0;
                    res.first_pixel_index = n_pd;
                    res.error_code        = tga_pkg::ERR_TRUNC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tga_pkg::PH_STOP;
            r_left  <= '0;
            r_run   <= 1'b0;
            r_slot  <= '0;
            r_hold  <= '0;
            r_pd    <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_run   <= n_run;
            r_slot  <= n_slot;
            r_hold  <= n_hold;
            r_pd    <= n_pd;
        end
    end

    assign o_emit   = i_advance && emit_c;
    assign o_result = res;

    `TGA_ASSERT_IMPL(a_empty_has_error, i_clk, i_rst_n, o_emit && (res.repeat_res == 8'd0), res.error_code != tga_pkg::ERR_NONE, "empty result without error")
    `TGA_ASSERT_NEXT(a_done_stops, i_clk, i_rst_n, o_emit && res.image_done, r_phase == tga_pkg::PH_STOP, "decoder still running after image end")
    `TGA_ASSERT_IMPL(a_overrun_done, i_clk, i_rst_n, o_emit && (res.error_code == tga_pkg::ERR_OVERRUN), res.image_done, "overrun without image end")
    `TGA_ASSERT_IMPL(a_rep_bound, i_clk, i_rst_n, o_emit, res.repeat_res <= tga_pkg::REP_MAX, "repeat count above packet maximum")

endmodule

FILE: design/tga_obuf.sv
// result register towards the output channel
`include "tga_rle_pixel_decoder_defines.svh"

module tga_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tga_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_free,
    output tga_pkg::t_result o_result
);

    logic             r_valid;
    tga_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `TGA_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, r_valid && !i_ready, !i_load, "result overwritten before taken")

endmodule
